### hdl/assert_macros.svh
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_AT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_AT(lbl, ante, cons, msg)
`define ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

### hdl/ssp_pkg.sv
package ssp_pkg;

  localparam int MAX_SLOTS_DEF       = 512;
  localparam int SPECIAL_START       = 8176;
  localparam int DIRECTORY_BASE      = 28;
  localparam int SLOT_BYTES          = 8;
  localparam int RECORD_HEADER_BYTES = 6;

  localparam int KEY_W  = 21;
  localparam int OFF_W  = 13;
  localparam int LEN_W  = 14;
  localparam int SLEN_W = 13;
  localparam int POS_W  = 10;
  localparam int DEST_W = 32;
  localparam int DEND_W = 17;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_CLEAR  = 1'b1;

  typedef enum logic [1:0] {
    STATUS_OK   = 2'd0,
    STATUS_FULL = 2'd1,
    STATUS_DUP  = 2'd2
  } status_t;

  typedef struct packed {
    logic              kind;
    logic [KEY_W-1:0]  first_char;
    logic [SLEN_W-1:0] label_len;
    logic [DEST_W-1:0] dest_block;
  } in_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [POS_W-1:0]  slot_position;
    logic [OFF_W-1:0]  record_offset;
    logic [OFF_W-1:0]  directory_end;
    logic [DEST_W-1:0] record_dest;
    logic [POS_W-1:0]  slot_count;
  } out_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [OFF_W-1:0] off;
    logic [LEN_W-1:0] len;
  } slot_t;

  typedef struct packed {
    logic             cmp_en;
    logic             shift_en;
    logic [KEY_W-1:0] key;
    logic [OFF_W-1:0] off;
    logic [LEN_W-1:0] len;
  } cell_ctl_t;

  function automatic int levels8(input int n);
    int l;
    l = 1;
    for (int k = 1; k < 6; k++) begin
      if ((1 << (3 * k)) < n) l = k + 1;
    end
    return l;
  endfunction

endpackage

### hdl/ssp_cell.sv
module ssp_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  ssp_pkg::cell_ctl_t ctl,
  input  logic              occupied,
  input  logic              prev_lt,
  input  ssp_pkg::slot_t    prev_slot,
  output ssp_pkg::slot_t    slot,
  output logic              lt,
  output logic              eq
);
  import ssp_pkg::*;

  slot_t slot_r;
  logic  lt_r;
  logic  eq_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lt_r <= 1'b0;
      eq_r <= 1'b0;
    end else if (ctl.cmp_en) begin
      lt_r <= occupied && (slot_r.key < ctl.key);
      eq_r <= occupied && (slot_r.key == ctl.key);
    end
  end

  // hold below the insert point, load the new slot at it, shift above it
  always_ff @(posedge clk) begin
    if (ctl.shift_en && !lt_r) begin
      if (prev_lt) begin
        slot_r <= '{key: ctl.key, off: ctl.off, len: ctl.len};
      end else begin
        slot_r <= prev_slot;
      end
    end
  end

  assign slot = slot_r;
  assign lt   = lt_r;
  assign eq   = eq_r;

endmodule

### hdl/ssp_ortree.sv
module ssp_ortree #(
  parameter int N     = 512,
  parameter int LANES = 10
) (
  input  logic                      clk,
  input  logic [N-1:0][LANES-1:0]   leaf,
  output logic [LANES-1:0]          root
);
  import ssp_pkg::*;

  localparam int LVL = levels8(N);
  localparam int PAD = 1 << (3 * LVL);

  logic [LANES-1:0] leaf_pad [PAD];
  logic [LANES-1:0] lvl_nxt  [LVL][PAD];
  logic [LANES-1:0] lvl_r    [LVL][PAD];

  always_comb begin
    for (int i = 0; i < PAD; i++) begin
      leaf_pad[i] = (i < N) ? leaf[i] : '0;
    end
  end

  for (genvar k = 0; k < LVL; k++) begin : g_lvl
    localparam int SIZE = PAD >> (3 * (k + 1));
    always_comb begin
      for (int j = 0; j < PAD; j++) begin
        lvl_nxt[k][j] = '0;
        if (j < SIZE) begin
          for (int c = 0; c < 8; c++) begin
            if (k == 0) begin
              lvl_nxt[k][j] = lvl_nxt[k][j] | leaf_pad[8 * j + c];
            end else begin
              lvl_nxt[k][j] = lvl_nxt[k][j] | lvl_r[(k > 0) ? k - 1 : 0][8 * j + c];
            end
          end
        end
      end
    end
    always_ff @(posedge clk) begin
      lvl_r[k] <= lvl_nxt[k];
    end
  end

  assign root = lvl_r[LVL-1][0];

endmodule

### hdl/sorted_slot_page_insert.sv
// Flow: an accepted item is compared in the slot cells, then passes the registered 8-ary
//   encoder tree that locates the insert point across the row of slot cells; the result
//   register then waits on out_stall while an earlier result is still held.
// in_stall stays high until the result of one item is written, so items do not overlap.
// Reset: slot count zero, lowest record at SPECIAL_START; slot contents stay
//   undefined until written, so no clearing pass runs.
module sorted_slot_page_insert #(
  parameter int MAX_SLOTS = ssp_pkg::MAX_SLOTS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  ssp_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output ssp_pkg::out_t out_data
);
  import ssp_pkg::*;
  `include "assert_macros.svh"

  localparam int CW    = $clog2(MAX_SLOTS + 1);
  localparam int IW    = $clog2(MAX_SLOTS);
  localparam int LANES = IW + 1;
  localparam int TLVL  = levels8(MAX_SLOTS);

  typedef enum logic {S_IDLE, S_WAIT} state_t;

  state_t           state_r, state_nxt;
  logic [2:0]       wait_r, wait_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic [OFF_W-1:0] lowest_r, lowest_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_t             out_r, out_nxt;

  logic             kind_r;
  logic             full_r;
  logic [KEY_W-1:0] key_r;
  logic [LEN_W-1:0] size_r;
  logic [OFF_W-1:0] off_r;
  logic [OFF_W-1:0] dend_r;
  logic [DEST_W-1:0] dest_r;

  logic             in_acc;
  logic             apply;
  logic             insert_go;
  logic [LEN_W-1:0] size_c;
  logic [CW:0]      cnt1_c;
  logic [DEND_W-1:0] dend_c;
  logic             fit_c;
  logic             full_c;
  logic [DEND_W-1:0] dir_used;

  cell_ctl_t        ctl;
  slot_t            slots [MAX_SLOTS];
  logic [MAX_SLOTS-1:0] lt_v;
  logic [MAX_SLOTS-1:0] eq_v;
  logic [MAX_SLOTS-1:0][LANES-1:0] leaf;
  logic [LANES-1:0] root;
  logic             dup;
  logic [IW-1:0]    pos;

  assign in_acc = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign apply = (state_r == S_WAIT) && (wait_r == 3'd0) && (!out_valid_r || !out_stall);
  assign dup = root[IW];
  assign pos = root[IW-1:0];
  assign insert_go = apply && (kind_r == KIND_INSERT) && !full_r && !dup;

  assign size_c = LEN_W'(RECORD_HEADER_BYTES) + LEN_W'(in_data.label_len);
  assign cnt1_c = {1'b0, count_r} + (CW+1)'(1);
  assign dend_c = DEND_W'(DIRECTORY_BASE) + DEND_W'(cnt1_c) * DEND_W'(SLOT_BYTES);
  assign fit_c = (size_c <= LEN_W'(lowest_r)) &&
                 (dend_c <= DEND_W'(lowest_r) - DEND_W'(size_c));
  assign full_c = (count_r >= CW'(MAX_SLOTS)) || !fit_c;
  assign dir_used = DEND_W'(DIRECTORY_BASE) + DEND_W'(count_r) * DEND_W'(SLOT_BYTES);

  assign ctl = '{cmp_en: in_acc, shift_en: insert_go, key: (in_acc ? in_data.first_char : key_r),
                 off: off_r, len: size_r};

  for (genvar i = 0; i < MAX_SLOTS; i++) begin : g_cell
    logic  occ;
    logic  p_lt;
    slot_t p_slot;
    logic  bnd;
    assign occ = (CW'(i) < count_r);
    if (i == 0) begin : g_head
      assign p_lt   = 1'b1;
      assign p_slot = '0;
    end else begin : g_body
      assign p_lt   = lt_v[i-1];
      assign p_slot = slots[i-1];
    end
    ssp_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .occupied  (occ),
      .prev_lt   (p_lt),
      .prev_slot (p_slot),
      .slot      (slots[i]),
      .lt        (lt_v[i]),
      .eq        (eq_v[i])
    );
    assign bnd = !lt_v[i] && p_lt;
    assign leaf[i] = {bnd && eq_v[i], (bnd ? IW'(i) : IW'(0))};
  end

  ssp_ortree #(.N(MAX_SLOTS), .LANES(LANES)) u_tree (
    .clk  (clk),
    .leaf (leaf),
    .root (root)
  );

  always_comb begin
    state_nxt     = state_r;
    wait_nxt      = wait_r;
    count_nxt     = count_r;
    lowest_nxt    = lowest_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_nxt       = out_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_WAIT;
          wait_nxt  = 3'(TLVL);
        end
      end
      S_WAIT: begin
        if (wait_r != 3'd0) begin
          wait_nxt = wait_r - 3'd1;
        end else if (apply) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          if (kind_r == KIND_CLEAR) begin
            count_nxt  = '0;
            lowest_nxt = OFF_W'(SPECIAL_START);
            out_nxt    = '{status: STATUS_OK, slot_position: '0,
                           record_offset: OFF_W'(SPECIAL_START),
                           directory_end: OFF_W'(DIRECTORY_BASE),
                           record_dest: '0, slot_count: '0};
          end else if (full_r) begin
            out_nxt = '{status: STATUS_FULL, slot_position: '0, record_offset: '0,
                        directory_end: '0, record_dest: '0, slot_count: POS_W'(count_r)};
          end else if (dup) begin
            out_nxt = '{status: STATUS_DUP, slot_position: POS_W'(pos), record_offset: '0,
                        directory_end: '0, record_dest: '0, slot_count: POS_W'(count_r)};
          end else begin
            count_nxt  = count_r + CW'(1);
            lowest_nxt = off_r;
            out_nxt    = '{status: STATUS_OK, slot_position: POS_W'(pos),
                           record_offset: off_r, directory_end: dend_r,
                           record_dest: dest_r, slot_count: POS_W'(count_r + CW'(1))};
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wait_r      <= 3'd0;
      count_r     <= '0;
      lowest_r    <= OFF_W'(SPECIAL_START);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wait_r      <= wait_nxt;
      count_r     <= count_nxt;
      lowest_r    <= lowest_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_r <= out_nxt;
    if (in_acc) begin
      kind_r <= in_data.kind;
      full_r <= full_c;
      key_r  <= in_data.first_char;
      size_r <= size_c;
      off_r  <= OFF_W'(DEND_W'(lowest_r) - DEND_W'(size_c));
      dend_r <= OFF_W'(dend_c);
      dest_r <= in_data.dest_block;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `ASSERT_NEXT(a_accept_busy, in_acc, state_r == S_WAIT, "accepted item did not start work")
  `ASSERT_AT(a_count_max, 1'b1, count_r <= CW'(MAX_SLOTS), "slot count above maximum")
  `ASSERT_NEXT(a_insert_count, insert_go, count_r == $past(count_r) + CW'(1), "insert lost count")
  `ASSERT_AT(a_no_overlap, state_r == S_IDLE, dir_used <= DEND_W'(lowest_r), "directory overlaps records")

endmodule
